// File: design/eight_bit_cpu_execute_unit_macros.svh
// Assertion macros shared by the execute unit.
`ifndef EIGHT_BIT_CPU_EXECUTE_UNIT_MACROS_SVH
`define EIGHT_BIT_CPU_EXECUTE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("execute unit assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("execute unit assertion failed");
`else
`define ASSERT_ALWAYS(label, cond)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: design/cpu8eu_pkg.sv
// Types, opcodes and widths of the eight-bit execute unit.
package cpu8eu_pkg;

    localparam int DATA_WORDS_DEF  = 2048;
    localparam int REG_COUNT_DEF   = 64;
    localparam int INSTR_WORDS_DEF = 1024;

    localparam int WORD_W     = 16;
    localparam int PC_W       = 10;
    localparam int DATA_W     = 8;
    localparam int RIDX_W     = 6;
    localparam int FIELD_W    = 6;
    // Non-negative data addresses a 6-bit signed immediate can reach
    localparam int IMM_SPAN   = 32;
    localparam int IMM_AW     = 5;
    localparam int WRAP_W     = 18;
    localparam int WRAP_STEPS = 6;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 32;

    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_LDI  = 4'd3;
    localparam logic [3:0] OP_BEQZ = 4'd4;
    localparam logic [3:0] OP_AND  = 4'd5;
    localparam logic [3:0] OP_OR   = 4'd6;
    localparam logic [3:0] OP_JR   = 4'd7;
    localparam logic [3:0] OP_SLC  = 4'd8;
    localparam logic [3:0] OP_SRC  = 4'd9;
    localparam logic [3:0] OP_LB   = 4'd10;
    localparam logic [3:0] OP_SB   = 4'd11;
    localparam logic [3:0] OP_NOP  = 4'd12;
    localparam logic [3:0] OP_HALT = 4'd13;

    typedef struct packed {
        logic z;
        logic s;
        logic n;
        logic v;
        logic c;
    } flags_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [PC_W-1:0]   addr;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] mdata;
        flags_t            flags;
    } alu_in_t;

    typedef struct packed {
        logic              wr;
        logic [RIDX_W-1:0] idx;
        logic [DATA_W-1:0] val;
        flags_t            flags;
        logic              redirect;
        logic [PC_W-1:0]   target;
        logic              halt;
        logic              mem_we;
        logic [IMM_AW-1:0] mem_addr;
    } alu_out_t;

endpackage

// File: design/eight_bit_cpu_execute_unit.sv
// Top level of the eight-bit execute unit: register file, data memory and pipeline control.
//
//  channel  dir  tdata fields, lowest bit up
//  s_*      in   instr_word[15:0] instr_address[25:16], zero [31:26]
//  m_*      out  reg_write reg_index reg_value zero sign negative overflow carry
//                redirect redirect_target halted (32 bits)
//
// One instruction per clock while the output is not stalled: an instruction reads the
// register file and data memory in the cycle it is transferred, executes in the next,
// and writes back and loads its result into the output register when it advances.
// Write-back to the instruction right behind is forwarded around the memory read.
// Reset clears valid bits of every register and of the 32 reachable data words at
// once, so no clearing pass is needed. A stalled output holds the execute stage,
// which holds s_tready low only when both stages are full.
`include "eight_bit_cpu_execute_unit_macros.svh"
module eight_bit_cpu_execute_unit
    import cpu8eu_pkg::*;
#(
    parameter int DATA_WORDS  = DATA_WORDS_DEF,
    parameter int REG_COUNT   = REG_COUNT_DEF,
    parameter int INSTR_WORDS = INSTR_WORDS_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // instr_word, instr_address, zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // reg_write, reg_index, reg_value, flag_zero,
                                           // flag_sign, flag_negative, flag_overflow,
                                           // flag_carry, redirect, redirect_target, halted
);

    localparam int RF_AW      = $clog2(REG_COUNT);
    localparam int DMEM_DEPTH = (DATA_WORDS < IMM_SPAN) ? DATA_WORDS : IMM_SPAN;
    localparam int DM_AW      = $clog2(DMEM_DEPTH);

    logic [DATA_W-1:0] rf_mem [REG_COUNT];
    logic [DATA_W-1:0] dm_mem [DMEM_DEPTH];

    logic [REG_COUNT-1:0]  rf_valid_reg;
    logic [DMEM_DEPTH-1:0] dm_valid_reg;
    flags_t                flags_reg;

    logic                  s1_valid_reg;
    logic [WORD_W-1:0]     s1_word_reg;
    logic [PC_W-1:0]       s1_addr_reg;
    logic [DATA_W-1:0]     ra_reg;
    logic [DATA_W-1:0]     rb_reg;
    logic [DATA_W-1:0]     md_reg;
    logic                  a_ok_reg, b_ok_reg, m_ok_reg;
    logic                  a_fwd_reg, b_fwd_reg, m_fwd_reg;
    logic [DATA_W-1:0]     a_fval_reg, b_fval_reg, m_fval_reg;

    logic                  out_valid_reg;
    logic [M_TDATA_W-1:0]  out_data_reg;

    logic [WORD_W-1:0]     in_word;
    logic [PC_W-1:0]       in_addr;
    logic [RF_AW-1:0]      in_r1;
    logic [RF_AW-1:0]      in_r2;
    logic [DM_AW-1:0]      in_ma;
    logic                  s_accept;
    logic                  advance;
    logic [RF_AW-1:0]      wr_idx;
    logic [DM_AW-1:0]      wr_ma;
    logic [DATA_W-1:0]     op_a;
    logic [DATA_W-1:0]     op_b;
    logic [DATA_W-1:0]     op_m;
    alu_in_t               alu_in;
    alu_out_t              alu_res;
    logic [M_TDATA_W-1:0]  out_data_next;

    assign in_word  = s_tdata[WORD_W-1:0];
    assign in_addr  = s_tdata[WORD_W+PC_W-1:WORD_W];
    assign in_r1    = in_word[6+RF_AW-1:6];
    assign in_r2    = in_word[RF_AW-1:0];
    assign in_ma    = in_word[DM_AW-1:0];
    assign wr_idx   = alu_res.idx[RF_AW-1:0];
    assign wr_ma    = alu_res.mem_addr[DM_AW-1:0];

    assign advance  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // Forwarded value first, then stored word, unwritten entries read as zero
    assign op_a = a_fwd_reg ? a_fval_reg : (a_ok_reg ? ra_reg : '0);
    assign op_b = b_fwd_reg ? b_fval_reg : (b_ok_reg ? rb_reg : '0);
    assign op_m = m_fwd_reg ? m_fval_reg : (m_ok_reg ? md_reg : '0);

    assign alu_in = '{word: s1_word_reg, addr: s1_addr_reg, a: op_a, b: op_b,
                      mdata: op_m, flags: flags_reg};

    cpu8eu_alu #(
        .DATA_WORDS  (DATA_WORDS),
        .INSTR_WORDS (INSTR_WORDS)
    ) u_alu (
        .op_in (alu_in),
        .res   (alu_res)
    );

    assign out_data_next = {alu_res.halt, alu_res.target, alu_res.redirect,
                            alu_res.flags.c, alu_res.flags.v, alu_res.flags.n,
                            alu_res.flags.s, alu_res.flags.z,
                            alu_res.val, alu_res.idx, alu_res.wr};

    // Register file and data memory: read on transfer, write back on advance
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            ra_reg <= rf_mem[in_r1];
            rb_reg <= rf_mem[in_r2];
            md_reg <= dm_mem[in_ma];
        end
        if (advance && alu_res.wr)
        begin
            rf_mem[wr_idx] <= alu_res.val;
        end
        if (advance && alu_res.mem_we)
        begin
            dm_mem[wr_ma] <= op_a;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_word_reg <= in_word;
            s1_addr_reg <= in_addr;
            a_ok_reg    <= rf_valid_reg[in_r1];
            b_ok_reg    <= rf_valid_reg[in_r2];
            m_ok_reg    <= dm_valid_reg[in_ma];
            a_fwd_reg   <= advance && alu_res.wr && (wr_idx == in_r1);
            b_fwd_reg   <= advance && alu_res.wr && (wr_idx == in_r2);
            m_fwd_reg   <= advance && alu_res.mem_we && (wr_ma == in_ma);
            a_fval_reg  <= alu_res.val;
            b_fval_reg  <= alu_res.val;
            m_fval_reg  <= op_a;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rf_valid_reg  <= '0;
            dm_valid_reg  <= '0;
            flags_reg     <= '0;
        end
        else
        begin
            if (s_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= alu_res.flags;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance && alu_res.wr)
            begin
                rf_valid_reg[wr_idx] <= 1'b1;
            end
            if (advance && alu_res.mem_we)
            begin
                dm_valid_reg[wr_ma] <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `ASSERT_ALWAYS(a_stall_only_full, !s_tready |-> (s1_valid_reg && out_valid_reg && !m_tready))
    `ASSERT_NEXT(a_transfer_fills, s_accept, s1_valid_reg)
    `ASSERT_ALWAYS(a_halt_clean, (m_tvalid && m_tdata[31]) |-> (!m_tdata[0] && !m_tdata[20]))
    `ASSERT_NEXT(a_wb_marks_valid, advance && alu_res.wr, rf_valid_reg[$past(wr_idx)])

endmodule

// File: design/cpu8eu_alu.sv
// Decode and execute datapath of the eight-bit execute unit.
module cpu8eu_alu
    import cpu8eu_pkg::*;
#(
    parameter int DATA_WORDS  = DATA_WORDS_DEF,
    parameter int INSTR_WORDS = INSTR_WORDS_DEF
)(
    input  alu_in_t  op_in,
    output alu_out_t res
);

    logic [3:0]          op;
    logic [FIELD_W-1:0]  r1;
    logic [FIELD_W-1:0]  r2;
    logic [DATA_W-1:0]   a;
    logic [DATA_W-1:0]   b;
    logic [DATA_W-1:0]   simm8;
    logic [DATA_W:0]     sum9;
    logic [DATA_W-1:0]   diff;
    logic [2*DATA_W-1:0] prod;
    logic [2*DATA_W-1:0] rot_l;
    logic [2*DATA_W-1:0] rot_r;
    logic                mem_ok;
    logic [WRAP_W-1:0]   beqz_pos;
    logic [PC_W-1:0]     beqz_tgt;
    logic [PC_W-1:0]     jr_tgt;
    logic [DATA_W-1:0]   val;
    logic                nz_upd;

    // Restoring reduction modulo INSTR_WORDS of a non-negative value
    function automatic logic [PC_W-1:0] wrap_pc(input logic [WRAP_W-1:0] v);
        logic [WRAP_W-1:0] r;
        r = v;
        for (int k = WRAP_STEPS - 1; k >= 0; k--) begin
            if (r >= (WRAP_W'(INSTR_WORDS) << k))
            begin
                r = r - (WRAP_W'(INSTR_WORDS) << k);
            end
        end
        return r[PC_W-1:0];
    endfunction

    assign op    = op_in.word[15:12];
    assign r1    = op_in.word[11:6];
    assign r2    = op_in.word[5:0];
    assign a     = op_in.a;
    assign b     = op_in.b;
    assign simm8 = {{(DATA_W - FIELD_W){r2[FIELD_W-1]}}, r2};
    assign sum9  = {1'b0, a} + {1'b0, b};
    assign diff  = a - b;
    assign prod  = a * b;
    assign rot_l = {a, a} << r2[2:0];
    assign rot_r = {a, a} >> r2[2:0];

    assign mem_ok = !r2[FIELD_W-1] && (32'(r2[IMM_AW-1:0]) < DATA_WORDS);

    // Offset by INSTR_WORDS keeps the sum non-negative; r2 ^ 0x20 is imm + 32
    assign beqz_pos = WRAP_W'(op_in.addr) + WRAP_W'(1) + WRAP_W'(INSTR_WORDS)
                    - WRAP_W'(IMM_SPAN) + WRAP_W'(r2 ^ 6'b100000);
    assign beqz_tgt = wrap_pc(beqz_pos);
    assign jr_tgt   = wrap_pc(WRAP_W'(a));

    always_comb
    begin
        res          = '0;
        res.flags    = op_in.flags;
        res.mem_addr = r2[IMM_AW-1:0];
        val          = '0;
        nz_upd       = 1'b0;
        case (op)
            OP_ADD:
            begin
                val         = sum9[DATA_W-1:0];
                res.wr      = 1'b1;
                nz_upd      = 1'b1;
                res.flags.c = sum9[DATA_W];
                res.flags.v = (a[7] ^ val[7]) & (b[7] ^ val[7]);
            end
            OP_SUB:
            begin
                val         = diff;
                res.wr      = 1'b1;
                nz_upd      = 1'b1;
                res.flags.v = (a[7] ^ b[7]) & (a[7] ^ val[7]);
            end
            OP_MUL:
            begin
                val    = prod[DATA_W-1:0];
                res.wr = 1'b1;
                nz_upd = 1'b1;
            end
            OP_LDI:
            begin
                val    = simm8;
                res.wr = 1'b1;
            end
            OP_BEQZ:
            begin
                if (a == '0)
                begin
                    res.redirect = 1'b1;
                    res.target   = beqz_tgt;
                end
            end
            OP_AND:
            begin
                val    = a & b;
                res.wr = 1'b1;
                nz_upd = 1'b1;
            end
            OP_OR:
            begin
                val    = a | b;
                res.wr = 1'b1;
                nz_upd = 1'b1;
            end
            OP_JR:
            begin
                res.redirect = 1'b1;
                res.target   = jr_tgt;
            end
            OP_SLC:
            begin
                val    = rot_l[2*DATA_W-1:DATA_W];
                res.wr = 1'b1;
                nz_upd = 1'b1;
            end
            OP_SRC:
            begin
                val    = rot_r[DATA_W-1:0];
                res.wr = 1'b1;
                nz_upd = 1'b1;
            end
            OP_LB:
            begin
                val    = mem_ok ? op_in.mdata : '0;
                res.wr = 1'b1;
            end
            OP_SB:
            begin
                res.mem_we = mem_ok;
            end
            OP_HALT:
            begin
                res.halt = 1'b1;
            end
            default:
            begin
                res.halt = 1'b0;
            end
        endcase
        if (nz_upd)
        begin
            res.flags.n = val[7];
            res.flags.z = (val == '0);
        end
        if (op == OP_ADD || op == OP_SUB)
        begin
            res.flags.s = res.flags.n ^ res.flags.v;
        end
        if (res.wr)
        begin
            res.idx = r1;
            res.val = val;
        end
    end

endmodule

// File: bench/tb_eight_bit_cpu_execute_unit.sv
// Self-checking testbench for the eight-bit execute unit: directed table, then random programs.
`timescale 1ns / 100ps

module tb_eight_bit_cpu_execute_unit;
    import cpu8eu_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int LONG_HOLD      = 60;

    // Same bit order as m_tdata, halted in bit 31 down to reg_write in bit 0
    typedef struct packed {
        logic              halted;
        logic [PC_W-1:0]   target;
        logic              redirect;
        logic              c;
        logic              v;
        logic              n;
        logic              s;
        logic              z;
        logic [DATA_W-1:0] value;
        logic [RIDX_W-1:0] index;
        logic              write;
    } exec_result_t;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic [PC_W-1:0]   pc;
        bit                typed;
        exec_result_t      result;
    } directed_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Predicted architectural state
    logic [DATA_W-1:0] regs [REG_COUNT_DEF];
    logic [DATA_W-1:0] dmem [DATA_WORDS_DEF];
    logic              fz, fs, fn, fv, fc;

    exec_result_t pending_results [$];
    int           mismatches = 0;
    int           src_idle_pct = 0;
    int           dst_idle_pct = 0;
    int           hold_len = 0;
    int           hold_left = 0;
    int           idle_cycles = 0;
    directed_row_t directed [26];

    eight_bit_cpu_execute_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // instr_word, instr_address, zero pad
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // reg_write ... halted, see exec_result_t
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [WORD_W-1:0] enc(input logic [3:0] op, input logic [5:0] r1,
                                              input logic [5:0] f2);
        return {op, r1, f2};
    endfunction

    function automatic exec_result_t reg_result(input logic [5:0] idx, input logic [7:0] val,
                                                input logic z, input logic s, input logic n,
                                                input logic v, input logic c);
        exec_result_t r;
        r = '0;
        r.write = 1'b1;
        r.index = idx;
        r.value = val;
        r.z = z;
        r.s = s;
        r.n = n;
        r.v = v;
        r.c = c;
        return r;
    endfunction

    function automatic exec_result_t execute_instr(input logic [WORD_W-1:0] word,
                                                   input logic [PC_W-1:0] pc);
        logic [3:0]        op;
        logic [5:0]        r1;
        logic [5:0]        f2;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] val;
        logic [8:0]        sum;
        logic [15:0]       twin;
        logic              upd_nz;
        int                simm;
        int                t;
        exec_result_t      r;
        op = word[15:12];
        r1 = word[11:6];
        f2 = word[5:0];
        a = regs[r1];
        b = regs[f2];
        simm = f2[5] ? int'(f2) - 64 : int'(f2);
        val = '0;
        upd_nz = 1'b0;
        r = '0;
        case (op)
            OP_ADD:
            begin
                sum = {1'b0, a} + {1'b0, b};
                val = sum[7:0];
                r.write = 1'b1;
                fc = sum[8];
                fv = (a[7] == b[7]) && (val[7] != a[7]);
                upd_nz = 1'b1;
            end
            OP_SUB:
            begin
                val = a - b;
                r.write = 1'b1;
                fv = (a[7] != b[7]) && (val[7] != a[7]);
                upd_nz = 1'b1;
            end
            OP_MUL:
            begin
                val = a * b;
                r.write = 1'b1;
                upd_nz = 1'b1;
            end
            OP_LDI:
            begin
                val = {{2{f2[5]}}, f2};
                r.write = 1'b1;
            end
            OP_BEQZ:
            begin
                if (a == '0)
                begin
                    t = (int'(pc) + 1 + simm) % INSTR_WORDS_DEF;
                    if (t < 0)
                        t += INSTR_WORDS_DEF;
                    r.redirect = 1'b1;
                    r.target = t[PC_W-1:0];
                end
            end
            OP_AND:
            begin
                val = a & b;
                r.write = 1'b1;
                upd_nz = 1'b1;
            end
            OP_OR:
            begin
                val = a | b;
                r.write = 1'b1;
                upd_nz = 1'b1;
            end
            OP_JR:
            begin
                r.redirect = 1'b1;
                r.target = PC_W'(a);
            end
            OP_SLC:
            begin
                twin = {a, a} << f2[2:0];
                val = twin[15:8];
                r.write = 1'b1;
                upd_nz = 1'b1;
            end
            OP_SRC:
            begin
                twin = {a, a} >> f2[2:0];
                val = twin[7:0];
                r.write = 1'b1;
                upd_nz = 1'b1;
            end
            OP_LB:
            begin
                val = (simm >= 0 && simm < DATA_WORDS_DEF) ? dmem[simm] : '0;
                r.write = 1'b1;
            end
            OP_SB:
            begin
                if (simm >= 0 && simm < DATA_WORDS_DEF)
                    dmem[simm] = a;
            end
            OP_HALT:
                r.halted = 1'b1;
            default:
                ;
        endcase
        if (upd_nz)
        begin
            fn = val[7];
            fz = (val == '0);
            // Sign follows only the add and subtract
            if (op == OP_ADD || op == OP_SUB)
                fs = fn ^ fv;
        end
        if (r.write)
        begin
            r.index = r1;
            r.value = val;
            regs[r1] = val;
        end
        r.z = fz;
        r.s = fs;
        r.n = fn;
        r.v = fv;
        r.c = fc;
        return r;
    endfunction

    // Offer one instruction and return at the edge that transfers it
    task automatic send_instr(input logic [WORD_W-1:0] word, input logic [PC_W-1:0] pc,
                              input bit typed, input exec_result_t typed_result);
        exec_result_t predicted;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_TDATA_W - WORD_W - PC_W){1'b0}}, pc, word};
        @(negedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        @(posedge clk);
        predicted = execute_instr(word, pc);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int count, input int src_pct, input int dst_pct,
                             input int hold_at);
        logic [3:0] op;
        logic [5:0] r1;
        logic [5:0] f2;
        logic [WORD_W-1:0] word;
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
                hold_len = LONG_HOLD;
            op = 4'($urandom_range(0, 15));
            // Favor a few registers so results feed the next instructions
            r1 = ($urandom_range(0, 1) != 0) ? 6'($urandom_range(0, 3)) : 6'($urandom_range(0, 63));
            f2 = ($urandom_range(0, 1) != 0) ? 6'($urandom_range(0, 3)) : 6'($urandom_range(0, 63));
            word = ($urandom_range(0, 9) == 0) ? WORD_W'($urandom) : enc(op, r1, f2);
            send_instr(word, PC_W'($urandom_range(0, INSTR_WORDS_DEF - 1)), 1'b0, '0);
        end
    endtask

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual)
        begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            mismatches++;
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_len != 0)
        begin
            hold_left = hold_len;
            hold_len = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end

    // Sample mid-cycle; the transfer completes on the next rising edge
    always @(negedge clk)
    begin
        exec_result_t got;
        exec_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = exec_result_t'(m_tdata);
            if (pending_results.size() == 0)
            begin
                $error("result with no instruction outstanding: %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("reg_write", want.write, got.write);
                check_field("reg_index", want.index, got.index);
                check_field("reg_value", want.value, got.value);
                check_field("flag_zero", want.z, got.z);
                check_field("flag_sign", want.s, got.s);
                check_field("flag_negative", want.n, got.n);
                check_field("flag_overflow", want.v, got.v);
                check_field("flag_carry", want.c, got.c);
                check_field("redirect", want.redirect, got.redirect);
                check_field("redirect_target", want.target, got.target);
                check_field("halted", want.halted, got.halted);
            end
        end
    end

    always @(negedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_eight_bit_cpu_execute_unit NOT OK");
            $finish;
        end
    end

    initial
    begin
        foreach (regs[i])
            regs[i] = '0;
        foreach (dmem[i])
            dmem[i] = '0;
        {fz, fs, fn, fv, fc} = '0;

        // Flags shown only where they follow directly from reset and the loads
        directed[0]  = '{enc(OP_ADD, 0, 0), 0, 1, reg_result(0, 8'h00, 1, 0, 0, 0, 0)};
        directed[1]  = '{enc(OP_LDI, 1, 6'h1F), 0, 1, reg_result(1, 8'h1F, 1, 0, 0, 0, 0)};
        directed[2]  = '{enc(OP_LDI, 2, 6'h20), 0, 1, reg_result(2, 8'hE0, 1, 0, 0, 0, 0)};
        directed[3]  = '{enc(OP_LDI, 63, 6'h3F), 0, 1, reg_result(63, 8'hFF, 1, 0, 0, 0, 0)};
        directed[4]  = '{enc(OP_ADD, 63, 63), 0, 1, reg_result(63, 8'hFE, 0, 1, 1, 0, 1)};
        directed[5]  = '{enc(OP_SUB, 2, 1), 1, 0, '0};
        directed[6]  = '{enc(OP_ADD, 1, 1), 2, 0, '0};
        directed[7]  = '{enc(OP_LDI, 3, 6'h01), 3, 0, '0};
        // Rotate by seven to reach 0x80, then add it to itself: zero, carry and overflow
        directed[8]  = '{enc(OP_SLC, 3, 6'h3F), 4, 0, '0};
        directed[9]  = '{enc(OP_ADD, 3, 3), 5, 0, '0};
        directed[10] = '{enc(OP_MUL, 1, 63), 6, 0, '0};
        directed[11] = '{enc(OP_AND, 63, 2), 7, 0, '0};
        directed[12] = '{enc(OP_OR, 0, 2), 8, 0, '0};
        directed[13] = '{enc(OP_SRC, 2, 6'h03), 9, 0, '0};
        directed[14] = '{enc(OP_SB, 63, 6'h1F), 10, 0, '0};
        directed[15] = '{enc(OP_SB, 63, 6'h20), 11, 0, '0};
        directed[16] = '{enc(OP_LB, 5, 6'h1F), 12, 0, '0};
        directed[17] = '{enc(OP_LB, 6, 6'h3F), 13, 0, '0};
        // Branches that wrap below zero and past the top of instruction memory; the one on r63 is not taken
        directed[18] = '{enc(OP_BEQZ, 3, 6'h20), 0, 0, '0};
        directed[19] = '{enc(OP_BEQZ, 63, 6'h1F), 1023, 0, '0};
        directed[20] = '{enc(OP_BEQZ, 3, 6'h1F), 1023, 0, '0};
        directed[21] = '{enc(OP_JR, 2, 6'h00), 14, 0, '0};
        directed[22] = '{enc(OP_NOP, 63, 6'h3F), 15, 0, '0};
        directed[23] = '{enc(OP_HALT, 0, 6'h00), 16, 0, '0};
        directed[24] = '{enc(4'd14, 6'h2A, 6'h15), 17, 0, '0};
        directed[25] = '{enc(4'd15, 6'h15, 6'h2A), 18, 0, '0};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 26;
        dst_idle_pct = 65;
        foreach (directed[i])
            send_instr(directed[i].word, directed[i].pc, directed[i].typed,
                       directed[i].result);

        run_phase(240, 26, 65, 100);
        drain_results();
        run_phase(230, 65, 26, 50);
        drain_results();
        run_phase(230, 0, 0, 120);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb_eight_bit_cpu_execute_unit OK");
        else
            $display("tb_eight_bit_cpu_execute_unit NOT OK");
        $finish;
    end

endmodule
